// ===== hdl/lifnr_pkg.sv =====
`default_nettype none

package lifnr_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int TERM_W    = 2 * DATA_W - FRAC_BITS;
   localparam int SUM_W     = TERM_W + 2;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [1:0] {
      FUNC_STEP  = 2'd0,
      FUNC_SPIKE = 2'd1,
      FUNC_CLEAR = 2'd2
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REFRACT_ENABLE = 3'd0,
      CSR_REFRACT_TICKS  = 3'd1,
      CSR_DECAY_FACTOR   = 3'd2,
      CSR_CURRENT_GAIN   = 3'd3,
      CSR_BIAS_TERM      = 3'd4,
      CSR_FIRE_THRESHOLD = 3'd5,
      CSR_REST_VOLTAGE   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic                     refract_enable;
      logic        [DATA_W-1:0] refract_ticks;
      logic signed [DATA_W-1:0] decay_factor;
      logic signed [DATA_W-1:0] current_gain;
      logic signed [DATA_W-1:0] bias_term;
      logic signed [DATA_W-1:0] fire_threshold;
      logic signed [DATA_W-1:0] rest_voltage;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      refract_enable: 1'b1,
      refract_ticks:  32'd0,
      decay_factor:   32'sd62259,
      current_gain:   32'sd65536,
      bias_term:      32'sd0,
      fire_threshold: 32'sd0,
      rest_voltage:   32'sd0
   };

   typedef struct packed {
      logic        [1:0]        func;
      logic        [DATA_W-1:0] step_time;
      logic signed [DATA_W-1:0] input_current;
   } item_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] voltage;
      logic        [DATA_W-1:0] last_fire_time;
      logic                     spike_flag;
   } state_type;

endpackage

`default_nettype wire

// ===== hdl/lifnr_if.sv =====
`default_nettype none

interface lifnr_req_if;
   import lifnr_pkg::*;
   logic                     valid;
   logic                     ready;
   logic        [1:0]        func;
   logic        [DATA_W-1:0] step_time;
   logic signed [DATA_W-1:0] input_current;

   modport source (output valid, output func, output step_time, output input_current,
                   input ready);
   modport sink   (input valid, input func, input step_time, input input_current,
                   output ready);
endinterface

interface lifnr_rsp_if;
   import lifnr_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     spike;
   logic signed [DATA_W-1:0] membrane_voltage;

   modport source (output valid, output spike, output membrane_voltage, input ready);
   modport sink   (input valid, input spike, input membrane_voltage, output ready);
endinterface

interface lifnr_csr_if;
   import lifnr_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [CSR_IDX_W-1:0]    index;
   logic [DATA_W-1:0]       data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/lifnr_update.sv =====
`default_nettype none

module lifnr_update (
   input  lifnr_pkg::cfg_type   cfg,
   input  lifnr_pkg::state_type state,
   input  lifnr_pkg::item_type  item,
   output lifnr_pkg::state_type state_next
);
   import lifnr_pkg::*;

   logic signed [2*DATA_W-1:0] prod_v;
   logic signed [2*DATA_W-1:0] prod_c;
   logic signed [TERM_W-1:0]   term_v;
   logic signed [TERM_W-1:0]   term_c;
   logic signed [SUM_W-1:0]    sum;
   logic signed [DATA_W-1:0]   v_sat;
   logic        [DATA_W-1:0]   elapsed;
   logic                       held;
   logic                       fire;

   always_comb begin
      prod_v = (2*DATA_W)'(cfg.decay_factor) * (2*DATA_W)'(state.voltage);
      prod_c = (2*DATA_W)'(cfg.current_gain) * (2*DATA_W)'(item.input_current);
   end

   // arithmetic shift floors toward minus infinity
   assign term_v = TERM_W'(prod_v >>> FRAC_BITS);
   assign term_c = TERM_W'(prod_c >>> FRAC_BITS);
   assign sum    = SUM_W'(term_v) + SUM_W'(term_c) + SUM_W'(cfg.bias_term);

   always_comb begin
      if (sum[SUM_W-1:DATA_W-1] == '0 || sum[SUM_W-1:DATA_W-1] == '1) begin
         v_sat = sum[DATA_W-1:0];
      end else if (sum[SUM_W-1]) begin
         v_sat = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         v_sat = {1'b0, {(DATA_W-1){1'b1}}};
      end
   end

   assign elapsed = item.step_time - state.last_fire_time;
   assign held    = cfg.refract_enable && (elapsed <= cfg.refract_ticks);
   assign fire    = v_sat >= cfg.fire_threshold;

   always_comb begin
      state_next = state;
      unique case (func_type'(item.func))
         FUNC_STEP: begin
            if (held) begin
               state_next.voltage    = cfg.rest_voltage;
               state_next.spike_flag = 1'b0;
            end else if (fire) begin
               state_next.voltage    = cfg.rest_voltage;
               state_next.spike_flag = 1'b1;
               if (cfg.refract_enable) begin
                  state_next.last_fire_time = item.step_time;
               end
            end else begin
               state_next.voltage    = v_sat;
               state_next.spike_flag = 1'b0;
            end
         end
         FUNC_SPIKE: begin
            state_next.voltage    = cfg.rest_voltage;
            state_next.spike_flag = 1'b1;
            if (cfg.refract_enable) begin
               state_next.last_fire_time = item.step_time;
            end
         end
         FUNC_CLEAR: begin
            state_next.voltage    = cfg.rest_voltage;
            state_next.spike_flag = 1'b0;
         end
         default: begin
            state_next = state;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/lif_neuron_refractory_update.sv =====
`default_nettype none

// Channel | Dir | Payload                          | Transfer
// req     | in  | func, step_time, input_current   | valid & ready
// rsp     | out | spike, membrane_voltage          | valid & ready
// csr     | in  | index (0..6), data               | valid & ready, ready always high
//
// One result per item. rsp valid rises once the item has passed the input register and
// the result register; one item per cycle sustained while rsp is not stalled. Input
// register, then the neuron update (two 32x32 multiplies, add, saturate, compare)
// into the result register, which also updates neuron state. Synchronous
// active-high reset restores register defaults and neuron state. rsp stall backs
// up through the input register; req stays ready while the input stage can drain.

module lif_neuron_refractory_update (
   input  wire logic  clock,
   input  wire logic  reset,
   lifnr_req_if.sink   req,
   lifnr_rsp_if.source rsp,
   lifnr_csr_if.sink   csr
);
   import lifnr_pkg::*;

   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   state_type state_ff;
   state_type state_in;
   item_type  item_ff;
   logic      in_valid_ff;
   logic      out_valid_ff;
   logic      out_spike_ff;
   logic signed [DATA_W-1:0] out_voltage_ff;
   logic      advance;
   logic      req_xfer;

   assign csr.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         unique case (csr_index_type'(csr.index))
            CSR_REFRACT_ENABLE: cfg_in.refract_enable = csr.data[0];
            CSR_REFRACT_TICKS:  cfg_in.refract_ticks  = csr.data;
            CSR_DECAY_FACTOR:   cfg_in.decay_factor   = csr.data;
            CSR_CURRENT_GAIN:   cfg_in.current_gain   = csr.data;
            CSR_BIAS_TERM:      cfg_in.bias_term      = csr.data;
            CSR_FIRE_THRESHOLD: cfg_in.fire_threshold = csr.data;
            CSR_REST_VOLTAGE:   cfg_in.rest_voltage   = csr.data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign req_xfer  = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         item_ff.func          <= req.func;
         item_ff.step_time     <= req.step_time;
         item_ff.input_current <= req.input_current;
      end
   end

   lifnr_update u_update (
      .cfg        (cfg_ff),
      .state      (state_ff),
      .item       (item_ff),
      .state_next (state_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.voltage        <= CFG_RESET.rest_voltage;
         state_ff.last_fire_time <= '0;
         state_ff.spike_flag     <= 1'b0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_spike_ff   <= state_in.spike_flag;
         out_voltage_ff <= state_in.voltage;
      end
   end

   assign rsp.valid            = out_valid_ff;
   assign rsp.spike            = out_spike_ff;
   assign rsp.membrane_voltage = out_voltage_ff;

   a_rsp_from_input: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $rose(out_valid_ff) |-> $past(in_valid_ff))
      else $error("result appeared without a held input item");

   a_result_is_state: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $past(advance) |->
         (out_voltage_ff == state_ff.voltage && out_spike_ff == state_ff.spike_flag))
      else $error("result register differs from neuron state");

   a_spike_at_rest: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) &&
      $past(advance && (item_ff.func == FUNC_STEP || item_ff.func == FUNC_SPIKE)) &&
      out_spike_ff |-> out_voltage_ff == $past(cfg_ff.rest_voltage))
      else $error("spike reported with voltage not at rest");

   a_plain_keeps_fire_time: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$past(cfg_ff.refract_enable) |-> $stable(state_ff.last_fire_time))
      else $error("last fire time changed in plain mode");

endmodule

`default_nettype wire
